### rtl/rdlt_pkg.sv
`timescale 1ns / 1ps

package rdlt_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STAY_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT  = 3'd5;

    // request opcodes
    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_DETECT = 1'b1;

    // one table slot as kept in the slot memory
    typedef struct packed {
        logic [14:0] owner_id;
        logic        in_region;
        logic        alarmed;
        logic [31:0] enter_ms;
        logic [31:0] seen_ms;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

### rtl/rdlt_ram.sv
`timescale 1ns / 1ps

module rdlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/roi_dwell_loiter_tracker.sv
`timescale 1ns / 1ps

// Long-stay tracker for a rectangular watch region. All slot state sits in one
// slot memory of TABLE_ENTRIES rows with a registered read, walked one row per
// cycle; only the per-slot used flags are flip-flops, cleared at reset, so
// there is no clearing pass. A request is taken when start is high and busy
// is low, one request at a time. A frame start keeps busy high while it ages
// out stale slots over a full table sweep. A detection keeps busy high for
// the table scan plus a read-modify-write of the chosen slot, and stops the
// scan early when its id is found; a detection with a negative id is
// dropped and busy never rises. The report of a detection is on the report
// ports for exactly one cycle, marked by report_valid, in the cycle in which
// busy falls; the receiver cannot stall it. A detection that finds neither
// its id nor a free slot gives no report. Configuration writes are always
// taken (cfg_ready is tied high) and must be made while idle.
module roi_dwell_loiter_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [31:0]                   time_ms,
    input  logic signed [15:0]            object_id,
    input  logic signed [12:0]            box_left,
    input  logic signed [12:0]            box_top,
    input  logic signed [12:0]            box_right,
    input  logic signed [12:0]            box_bottom,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rdlt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output logic                          report_valid,
    output logic [14:0]                   report_id,
    output logic                          inside_region,
    output logic                          alarm_latched,
    output logic [31:0]                   dwell_ms,
    output logic                          long_stay_event,
    output logic signed [12:0]            event_left,
    output logic signed [12:0]            event_top,
    output logic signed [12:0]            event_right,
    output logic signed [12:0]            event_bottom
);

    import rdlt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    // configuration registers
    logic [11:0] region_left_reg;
    logic [11:0] region_top_reg;
    logic [11:0] region_right_reg;
    logic [11:0] region_bottom_reg;
    logic [31:0] stay_limit_reg;
    logic [31:0] lost_timeout_reg;

    // control and working registers
    state_t                    state_reg;
    logic [TABLE_ENTRIES-1:0]  slot_used_reg;
    logic [CNT_W-1:0]          scan_addr_reg;
    logic                      cmp_valid_reg;
    logic [ADDR_W-1:0]         cmp_addr_reg;
    logic                      free_found_reg;
    logic [ADDR_W-1:0]         free_addr_reg;
    logic [ADDR_W-1:0]         slot_reg;
    slot_t                     entry_reg;
    logic [31:0]               frame_time_reg;
    logic [14:0]               id_reg;
    logic signed [12:0]        bl_reg;
    logic signed [12:0]        bt_reg;
    logic signed [12:0]        br_reg;
    logic signed [12:0]        bb_reg;

    // output registers
    logic                      report_valid_reg;
    logic [14:0]               report_id_reg;
    logic                      inside_region_reg;
    logic                      alarm_latched_reg;
    logic [31:0]               dwell_ms_reg;
    logic                      long_stay_event_reg;
    logic signed [12:0]        event_left_reg;
    logic signed [12:0]        event_top_reg;
    logic signed [12:0]        event_right_reg;
    logic signed [12:0]        event_bottom_reg;

    // memory ports and scan decisions
    logic                      scan_live;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    slot_t                     ram_rdata;
    logic                      ram_we;
    logic [SLOT_W-1:0]         ram_wdata;
    logic                      cmp_used;
    logic                      id_hit;
    logic                      free_hit;
    logic                      stale;
    logic                      scan_last;
    logic [31:0]               age;

    // foot point and region test
    logic signed [13:0]        foot_sum;
    logic signed [13:0]        foot_x;
    logic                      foot_in;

    // slot update
    logic [31:0]               dwell_run;
    logic [31:0]               dwell_next;
    logic                      alarmed_base;
    logic                      event_next;
    slot_t                     entry_next;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_left_reg   <= 12'd80;
            region_top_reg    <= 12'd80;
            region_right_reg  <= 12'd560;
            region_bottom_reg <= 12'd560;
            stay_limit_reg    <= 32'd30000;
            lost_timeout_reg  <= 32'd3000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_REGION_LEFT:   region_left_reg   <= cfg_data[11:0];
                REG_REGION_TOP:    region_top_reg    <= cfg_data[11:0];
                REG_REGION_RIGHT:  region_right_reg  <= cfg_data[11:0];
                REG_REGION_BOTTOM: region_bottom_reg <= cfg_data[11:0];
                REG_STAY_LIMIT:    stay_limit_reg    <= cfg_data;
                REG_LOST_TIMEOUT:  lost_timeout_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // table scan: one read issued per cycle, compared in the cycle after
    assign scan_live = ((state_reg == ST_SWEEP) || (state_reg == ST_SEARCH)) &&
                       (scan_addr_reg < CNT_W'(TABLE_ENTRIES));
    assign ram_re    = scan_live;
    assign ram_raddr = scan_addr_reg[ADDR_W-1:0];

    assign cmp_used  = slot_used_reg[cmp_addr_reg];
    assign age       = frame_time_reg - ram_rdata.seen_ms;
    assign id_hit    = cmp_valid_reg && cmp_used && (ram_rdata.owner_id == id_reg);
    assign free_hit  = cmp_valid_reg && !cmp_used && !free_found_reg;
    assign stale     = cmp_valid_reg && cmp_used && (age > lost_timeout_reg);
    assign scan_last = cmp_valid_reg && (scan_addr_reg == CNT_W'(TABLE_ENTRIES));

    function automatic logic signed [13:0] box_sum_ext(input logic signed [12:0] v);
        box_sum_ext = {v[12], v};
    endfunction

    // foot point x is the box centre, truncated toward zero
    always_comb
    begin
        foot_sum = 14'(box_sum_ext(bl_reg)) + 14'(box_sum_ext(br_reg));
        foot_x   = (foot_sum + (foot_sum[13] ? 14'sd1 : 14'sd0)) >>> 1;
        foot_in  = (foot_x >= $signed({2'b00, region_left_reg})) &&
                   (foot_x <= $signed({2'b00, region_right_reg})) &&
                   (bb_reg >= $signed({1'b0, region_top_reg})) &&
                   (bb_reg <= $signed({1'b0, region_bottom_reg}));
    end

    // read-modify-write of the chosen slot
    always_comb
    begin
        dwell_run    = frame_time_reg - entry_reg.enter_ms;
        entry_next   = entry_reg;
        entry_next.owner_id = id_reg;
        entry_next.seen_ms  = frame_time_reg;
        dwell_next   = 32'd0;
        alarmed_base = 1'b0;
        event_next   = 1'b0;
        if (foot_in)
        begin
            if (!entry_reg.in_region)
            begin
                entry_next.in_region = 1'b1;
                entry_next.enter_ms  = frame_time_reg;
                alarmed_base         = 1'b0;
                dwell_next           = 32'd0;
            end
            else
            begin
                alarmed_base = entry_reg.alarmed;
                dwell_next   = dwell_run;
            end
            event_next         = (dwell_next >= stay_limit_reg) && !alarmed_base;
            entry_next.alarmed = alarmed_base || event_next;
        end
        else
        begin
            entry_next.in_region = 1'b0;
            entry_next.alarmed   = 1'b0;
            entry_next.enter_ms  = 32'd0;
        end
    end

    assign ram_we    = (state_reg == ST_UPDATE);
    assign ram_wdata = entry_next;

    rdlt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer, used flags and report registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            slot_used_reg       <= '0;
            scan_addr_reg       <= '0;
            cmp_valid_reg       <= 1'b0;
            cmp_addr_reg        <= '0;
            free_found_reg      <= 1'b0;
            free_addr_reg       <= '0;
            slot_reg            <= '0;
            entry_reg           <= '0;
            frame_time_reg      <= 32'd0;
            id_reg              <= '0;
            bl_reg              <= '0;
            bt_reg              <= '0;
            br_reg              <= '0;
            bb_reg              <= '0;
            report_valid_reg    <= 1'b0;
            report_id_reg       <= '0;
            inside_region_reg   <= 1'b0;
            alarm_latched_reg   <= 1'b0;
            dwell_ms_reg        <= 32'd0;
            long_stay_event_reg <= 1'b0;
            event_left_reg      <= '0;
            event_top_reg       <= '0;
            event_right_reg     <= '0;
            event_bottom_reg    <= '0;
        end
        else
        begin
            report_valid_reg <= 1'b0;

            // read pipeline advance
            if (scan_live)
            begin
                scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                cmp_addr_reg  <= scan_addr_reg[ADDR_W-1:0];
                cmp_valid_reg <= 1'b1;
            end
            else
            begin
                cmp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    scan_addr_reg  <= '0;
                    cmp_valid_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    if (start)
                    begin
                        if (opcode == OP_FRAME)
                        begin
                            frame_time_reg <= time_ms;
                            state_reg      <= ST_SWEEP;
                        end
                        else if (!object_id[15])
                        begin
                            id_reg    <= object_id[14:0];
                            bl_reg    <= box_left;
                            bt_reg    <= box_top;
                            br_reg    <= box_right;
                            bb_reg    <= box_bottom;
                            state_reg <= ST_SEARCH;
                        end
                    end
                end

                ST_SWEEP:
                begin
                    // free slots unseen for longer than the timeout
                    if (stale)
                    begin
                        slot_used_reg[cmp_addr_reg] <= 1'b0;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_SEARCH:
                begin
                    if (free_hit)
                    begin
                        free_found_reg <= 1'b1;
                        free_addr_reg  <= cmp_addr_reg;
                    end
                    if (id_hit)
                    begin
                        entry_reg <= ram_rdata;
                        slot_reg  <= cmp_addr_reg;
                        state_reg <= ST_UPDATE;
                    end
                    else if (scan_last)
                    begin
                        // no match: take the lowest free slot, if any
                        entry_reg <= '0;
                        slot_reg  <= free_found_reg ? free_addr_reg : cmp_addr_reg;
                        if (free_found_reg || free_hit)
                        begin
                            state_reg <= ST_UPDATE;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_UPDATE:
                begin
                    slot_used_reg[slot_reg] <= 1'b1;
                    report_valid_reg    <= 1'b1;
                    report_id_reg       <= id_reg;
                    inside_region_reg   <= foot_in;
                    alarm_latched_reg   <= entry_next.alarmed;
                    dwell_ms_reg        <= dwell_next;
                    long_stay_event_reg <= event_next;
                    event_left_reg      <= event_next ? bl_reg : 13'sd0;
                    event_top_reg       <= event_next ? bt_reg : 13'sd0;
                    event_right_reg     <= event_next ? br_reg : 13'sd0;
                    event_bottom_reg    <= event_next ? bb_reg : 13'sd0;
                    state_reg           <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign report_valid    = report_valid_reg;
    assign report_id       = report_id_reg;
    assign inside_region   = inside_region_reg;
    assign alarm_latched   = alarm_latched_reg;
    assign dwell_ms        = dwell_ms_reg;
    assign long_stay_event = long_stay_event_reg;
    assign event_left      = event_left_reg;
    assign event_top       = event_top_reg;
    assign event_right     = event_right_reg;
    assign event_bottom    = event_bottom_reg;

    // a report only follows a slot write-back
    a_report_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> $past(state_reg == ST_UPDATE))
        else $error("report without slot update");

    // an event implies the alarm is latched and the track is inside
    a_event_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && long_stay_event) |-> (alarm_latched && inside_region))
        else $error("long-stay event without latched alarm inside region");

    // a track outside the region has no dwell and no alarm
    a_outside_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && !inside_region) |-> (dwell_ms == 32'd0 && !alarm_latched))
        else $error("dwell or alarm reported outside region");

    // the compare stage only runs during a table scan or the write-back after a hit
    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> ((state_reg == ST_SWEEP) || (state_reg == ST_SEARCH) ||
                           (state_reg == ST_UPDATE)))
        else $error("compare stage active outside a scan");

endmodule

### bench/roi_dwell_loiter_tracker_test.sv
`timescale 1ns / 1ps

module roi_dwell_loiter_tracker_test;

    import rdlt_pkg::*;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int ITEM_GOAL     = 1500;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
    localparam int QUIET_LIMIT   = 10 * (TABLE_ENTRIES + 24);

    // one expected report
    typedef struct {
        bit [14:0] id;
        bit        in_win;
        bit        alarm;
        bit [31:0] dwell;
        bit        fired;
        bit [12:0] box_l;
        bit [12:0] box_t;
        bit [12:0] box_r;
        bit [12:0] box_b;
    } report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  opcode;
    logic [31:0]           time_ms;
    logic signed [15:0]    object_id;
    logic signed [12:0]    box_left;
    logic signed [12:0]    box_top;
    logic signed [12:0]    box_right;
    logic signed [12:0]    box_bottom;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [31:0]           cfg_data;
    logic                  report_valid;
    logic [14:0]           report_id;
    logic                  inside_region;
    logic                  alarm_latched;
    logic [31:0]           dwell_ms;
    logic                  long_stay_event;
    logic signed [12:0]    event_left;
    logic signed [12:0]    event_top;
    logic signed [12:0]    event_right;
    logic signed [12:0]    event_bottom;

    // track table as the testbench expects it
    bit        trk_used  [TABLE_ENTRIES];
    bit [14:0] trk_id    [TABLE_ENTRIES];
    bit        trk_in    [TABLE_ENTRIES];
    bit        trk_alarm [TABLE_ENTRIES];
    bit [31:0] trk_enter [TABLE_ENTRIES];
    bit [31:0] trk_seen  [TABLE_ENTRIES];
    bit [31:0] now_ms;

    // watch window and timing registers
    bit [11:0] win_left;
    bit [11:0] win_top;
    bit [11:0] win_right;
    bit [11:0] win_bottom;
    bit [31:0] stay_limit;
    bit [31:0] lost_timeout;

    report_t expected_reports [$];
    int      errors      = 0;
    int      items_sent  = 0;
    int      burst_left  = 0;
    int      quiet_cycles = 0;

    roi_dwell_loiter_tracker uut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // expected outcome of one accepted request
    function automatic void predict_request(input bit op, input bit [31:0] t,
                                            input bit signed [15:0] oid,
                                            input bit signed [12:0] bl, bt, br, bb);
        int        i;
        int        slot;
        int        fx;
        int        fy;
        bit        in_win;
        bit        fired;
        bit [31:0] dwell;
        bit [31:0] age;
        report_t   rep;
        slot  = -1;
        fired = 1'b0;
        dwell = '0;
        // frame start ages out stale tracks
        if (op == OP_FRAME)
        begin
            now_ms = t;
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                age = now_ms - trk_seen[i];
                if (trk_used[i] && age > lost_timeout)
                    trk_used[i] = 1'b0;
            end
            return;
        end
        if (oid < 0)
            return;
        // lookup, then lowest free slot
        for (i = 0; i < TABLE_ENTRIES && slot < 0; i++)
            if (trk_used[i] && trk_id[i] == oid[14:0])
                slot = i;
        for (i = 0; i < TABLE_ENTRIES && slot < 0; i++)
            if (!trk_used[i])
            begin
                slot         = i;
                trk_used[i]  = 1'b1;
                trk_id[i]    = oid[14:0];
                trk_in[i]    = 1'b0;
                trk_alarm[i] = 1'b0;
                trk_enter[i] = '0;
                trk_seen[i]  = '0;
            end
        if (slot < 0)
            return;
        // foot point against the window
        fx = (int'(bl) + int'(br)) / 2;
        fy = int'(bb);
        in_win = fx >= int'(win_left) && fx <= int'(win_right) &&
                 fy >= int'(win_top) && fy <= int'(win_bottom);
        trk_seen[slot] = now_ms;
        if (in_win)
        begin
            if (!trk_in[slot])
            begin
                trk_in[slot]    = 1'b1;
                trk_alarm[slot] = 1'b0;
                trk_enter[slot] = now_ms;
                dwell           = '0;
            end
            else
                dwell = now_ms - trk_enter[slot];
            if (dwell >= stay_limit && !trk_alarm[slot])
            begin
                trk_alarm[slot] = 1'b1;
                fired           = 1'b1;
            end
        end
        else
        begin
            trk_in[slot]    = 1'b0;
            trk_alarm[slot] = 1'b0;
            trk_enter[slot] = '0;
        end
        rep.id     = oid[14:0];
        rep.in_win = in_win;
        rep.alarm  = trk_alarm[slot];
        rep.dwell  = dwell;
        rep.fired  = fired;
        rep.box_l  = fired ? bl : '0;
        rep.box_t  = fired ? bt : '0;
        rep.box_r  = fired ? br : '0;
        rep.box_b  = fired ? bb : '0;
        expected_reports.push_back(rep);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    // report checker
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && report_valid)
        begin
            if (expected_reports.size() == 0)
            begin
                errors++;
                $display("%0t: report for id %0d with none pending", $time, report_id);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("report_id", 32'(want.id), 32'(report_id));
                check_field("inside_region", 32'(want.in_win), 32'(inside_region));
                check_field("alarm_latched", 32'(want.alarm), 32'(alarm_latched));
                check_field("dwell_ms", want.dwell, dwell_ms);
                check_field("long_stay_event", 32'(want.fired), 32'(long_stay_event));
                check_field("event_left", 32'(want.box_l), 32'($unsigned(event_left)));
                check_field("event_top", 32'(want.box_t), 32'($unsigned(event_top)));
                check_field("event_right", 32'(want.box_r), 32'($unsigned(event_right)));
                check_field("event_bottom", 32'(want.box_b),
                            32'($unsigned(event_bottom)));
            end
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || report_valid || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // one request through the start/busy handshake, bursts with random gaps
    task automatic send_request(input bit op, input bit [31:0] t,
                                input bit signed [15:0] oid,
                                input bit signed [12:0] bl, bt, br, bb);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        start      <= 1'b1;
        opcode     <= op;
        time_ms    <= t;
        object_id  <= oid;
        box_left   <= bl;
        box_top    <= bt;
        box_right  <= br;
        box_bottom <= bb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(op, t, oid, bl, bt, br, bb);
        if (!(op == OP_DETECT && oid < 0))
            items_sent++;
    endtask

    task automatic send_frame(input bit [31:0] t);
        send_request(OP_FRAME, t, 16'($urandom()), 13'($urandom()), 13'($urandom()),
                     13'($urandom()), 13'($urandom()));
    endtask

    task automatic send_detect(input bit signed [15:0] oid,
                               input bit signed [12:0] bl, bt, br, bb);
        send_request(OP_DETECT, $urandom(), oid, bl, bt, br, bb);
    endtask

    // box whose foot point lands on fx, fy
    function automatic void foot_box(input int fx, input int fy,
                                     output bit signed [12:0] bl, bt, br, bb);
        int w;
        int h;
        int odd;
        int lo;
        int hi;
        int top;
        w   = $urandom_range(0, 120);
        h   = $urandom_range(0, 200);
        odd = (fx >= 0) ? int'($urandom_range(0, 1)) : 0;
        lo  = fx - w;
        hi  = fx + w + odd;
        if (lo < -4096 || hi > 4095)
        begin
            lo = fx;
            hi = fx;
        end
        top = fy - h;
        if (top < -4096)
            top = -4096;
        bl = 13'(lo);
        br = 13'(hi);
        bt = 13'(top);
        bb = 13'(fy);
    endfunction

    // pause the sender until every pending report is in
    task automatic drain_reports();
        @(negedge clk);
        start <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_REGION_LEFT:   win_left     = val[11:0];
            REG_REGION_TOP:    win_top      = val[11:0];
            REG_REGION_RIGHT:  win_right    = val[11:0];
            REG_REGION_BOTTOM: win_bottom   = val[11:0];
            REG_STAY_LIMIT:    stay_limit   = val;
            REG_LOST_TIMEOUT:  lost_timeout = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // idle the block, then load every register; junk above the 12-bit edges
    task automatic set_config(input bit [11:0] l, t, r, b, input bit [31:0] limit, timeout);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_REGION_LEFT, {20'($urandom()), l});
        write_reg(REG_REGION_TOP, {20'($urandom()), t});
        write_reg(REG_REGION_RIGHT, {20'($urandom()), r});
        write_reg(REG_REGION_BOTTOM, {20'($urandom()), b});
        write_reg(REG_STAY_LIMIT, limit);
        write_reg(REG_LOST_TIMEOUT, timeout);
    endtask

    // reset values, window edges, truncation, negative ids, time wrap
    task automatic test_reset_defaults();
        send_detect(16'sd0, 13'sd250, 13'sd200, 13'sd350, 13'sd300);
        send_detect(16'hFFFF, 13'sd300, 13'sd0, 13'sd300, 13'sd300);
        send_detect(16'h8000, 13'sd300, 13'sd0, 13'sd300, 13'sd300);
        send_frame(32'd1000);
        send_detect(16'sd0, 13'sd250, 13'sd200, 13'sd350, 13'sd300);
        send_detect(16'h7FFF, 13'h1000, 13'h1000, 13'h0FFF, 13'h0FFF);
        send_detect(16'sd1, 13'sd79, 13'sd0, 13'sd82, 13'sd80);
        send_detect(16'sd2, 13'sd78, 13'sd0, 13'sd81, 13'sd300);
        send_detect(16'sd3, 13'sd560, 13'sd0, 13'sd560, 13'sd560);
        send_detect(16'sd4, 13'sd561, 13'sd0, 13'sd561, 13'sd560);
        send_detect(16'sd5, 13'sd300, 13'sd0, 13'sd300, 13'sd561);
        send_detect(16'sd6, 13'sd300, 13'sd0, 13'sd300, 13'sd79);
        send_detect(16'sd7, -13'sd3, 13'sd0, 13'sd0, 13'sd100);
        send_detect(16'sd8, 13'h1000, 13'h1000, 13'h1000, 13'h1000);
        send_detect(16'sd0, 13'sd300, 13'sd0, 13'sd300, 13'sd600);
        // time steps back, every track ages out
        send_frame(32'd100);
        send_detect(16'sd0, 13'sd300, 13'sd0, 13'sd300, 13'sd300);
        send_frame(32'hFFFF_FF00);
        send_detect(16'sd9, 13'sd300, 13'sd0, 13'sd300, 13'sd300);
        // wrap past zero keeps the track, dwell taken modulo 2^32
        send_frame(32'h0000_0100);
        send_detect(16'sd9, 13'sd300, 13'sd0, 13'sd300, 13'sd300);
        send_detect(16'sd0, 13'sd300, 13'sd0, 13'sd300, 13'sd300);
    endtask

    // event on entry, copied box, zero timeout, spare register indexes
    task automatic test_zero_limit();
        set_config(12'd100, 12'd50, 12'd200, 12'd150, 32'd0, 32'd0);
        write_reg(REG_SPARE_6, $urandom());
        write_reg(REG_SPARE_7, $urandom());
        send_frame(32'd5000);
        send_detect(16'sd10, -13'sd100, 13'h1000, 13'sd400, 13'sd100);
        send_detect(16'sd10, -13'sd100, 13'h1000, 13'sd400, 13'sd100);
        send_detect(16'sd10, 13'sd150, 13'sd0, 13'sd150, 13'sd151);
        send_detect(16'sd10, 13'sd100, 13'sd0, 13'sd100, 13'sd50);
        send_frame(32'd5000);
        send_detect(16'sd10, 13'sd200, 13'sd0, 13'sd200, 13'sd150);
        send_frame(32'd5001);
        send_detect(16'sd10, 13'sd200, 13'sd0, 13'sd200, 13'sd150);
    endtask

    // empty windows, a one-pixel window, the full window with all-ones limits
    task automatic test_region_edges();
        bit [31:0] base;
        set_config(12'd300, 12'd300, 12'd299, 12'd600, 32'd10, 32'd3000);
        send_frame(now_ms + 32'd7);
        send_detect(16'sd11, 13'sd300, 13'sd0, 13'sd300, 13'sd300);
        send_detect(16'sd11, 13'sd299, 13'sd0, 13'sd299, 13'sd300);
        set_config(12'd300, 12'd300, 12'd600, 12'd299, 32'd10, 32'd3000);
        send_detect(16'sd12, 13'sd300, 13'sd0, 13'sd300, 13'sd300);
        set_config(12'd1000, 12'd1000, 12'd1000, 12'd1000, 32'd1, 32'hFFFF_FFFF);
        send_frame(now_ms + 32'd5);
        send_detect(16'sd13, 13'sd999, 13'sd0, 13'sd1001, 13'sd1000);
        send_frame(now_ms + 32'd1);
        send_detect(16'sd13, 13'sd1000, 13'sd0, 13'sd1000, 13'sd1000);
        set_config(12'd0, 12'd0, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        base = now_ms + 32'd3;
        send_frame(base);
        send_detect(16'sd14, 13'sd0, 13'sd0, 13'sd0, 13'sd0);
        send_detect(16'sd15, 13'h0FFF, 13'h0FFF, 13'h0FFF, 13'h0FFF);
        send_detect(16'sd16, -13'sd2, 13'sd0, 13'sd0, 13'sd0);
        // one step back is the largest age and the largest dwell
        send_frame(base - 32'd1);
        send_detect(16'sd14, 13'sd0, 13'sd0, 13'sd0, 13'sd0);
    endtask

    // fill every slot, then new ids find no room
    task automatic test_table_full();
        int               k;
        bit [31:0]        base;
        bit signed [15:0] full_ids [TABLE_ENTRIES];
        bit signed [12:0] l, t, r, b;
        set_config(12'd100, 12'd100, 12'd3000, 12'd3000, 32'd2000, 32'd0);
        base = now_ms + 32'd10;
        send_frame(base);
        send_frame(base + 32'd1);
        set_config(12'd100, 12'd100, 12'd3000, 12'd3000, 32'd2000, 32'hFFFF_FFFF);
        for (k = 0; k < TABLE_ENTRIES; k++)
        begin
            full_ids[k] = 16'(k * 128 + 2 * int'($urandom_range(0, 63)));
            foot_box($urandom_range(0, 4095), $urandom_range(0, 4095), l, t, r, b);
            send_detect(full_ids[k], l, t, r, b);
        end
        for (k = 0; k < 6; k++)
        begin
            foot_box($urandom_range(0, 4095), $urandom_range(0, 4095), l, t, r, b);
            send_detect(16'(128 * int'($urandom_range(0, 255)) +
                            2 * int'($urandom_range(0, 63)) + 1), l, t, r, b);
        end
        for (k = 0; k < 4; k++)
        begin
            foot_box($urandom_range(200, 2900), $urandom_range(200, 2900), l, t, r, b);
            send_detect(full_ids[$urandom_range(0, TABLE_ENTRIES - 1)], l, t, r, b);
        end
        send_frame(base + 32'd5000);
        send_detect(16'sd1, 13'sd500, 13'sd0, 13'sd500, 13'sd500);
        foot_box(1500, 1500, l, t, r, b);
        send_detect(full_ids[$urandom_range(0, TABLE_ENTRIES - 1)], l, t, r, b);
    endtask

    // frames with a few detections from a pool of live tracks, plus noise
    task automatic test_random_traffic();
        int               p;
        int               k;
        int               n;
        int               roll;
        int               goal;
        int               fx;
        int               fy;
        bit [11:0]        l;
        bit [11:0]        t;
        bit [31:0]        next_ms;
        bit signed [15:0] pool_ids [10];
        bit               keep_in  [10];
        bit signed [12:0] bl, bt, br, bb;
        for (p = 0; p < 4; p++)
        begin
            l = 12'($urandom_range(0, 4000));
            t = 12'($urandom_range(0, 4000));
            case (p)
                0: set_config(l / 4, t / 4, 12'(l / 4 + $urandom_range(0, 1500)),
                              12'(t / 4 + $urandom_range(0, 1500)),
                              $urandom_range(500, 3000), $urandom_range(1000, 4000));
                1: set_config(12'd0, 12'd0, 12'd4095, 12'd4095,
                              $urandom_range(0, 1000), $urandom_range(0, 800));
                2: set_config(l, t, 12'(l + $urandom_range(0, 95)),
                              12'(t + $urandom_range(0, 95)),
                              $urandom_range(1, 2000), 32'hFFFF_FFFF);
                default: set_config(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                    12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                    $urandom_range(0, 3000), $urandom());
            endcase
            for (k = 0; k < 10; k++)
            begin
                pool_ids[k] = (k < 5) ? 16'(k) : 16'($urandom_range(0, 32767));
                keep_in[k]  = $urandom_range(0, 3) != 0;
            end
            goal = items_sent + (ITEM_GOAL - items_sent) / (4 - p);
            while (items_sent < goal)
            begin
                next_ms = ($urandom_range(0, 24) == 0) ? $urandom()
                                                       : now_ms + $urandom_range(0, 1200);
                send_frame(next_ms);
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    k    = $urandom_range(0, 9);
                    roll = $urandom_range(0, 19);
                    if (roll == 0)
                        send_request(1'($urandom_range(0, 1)), $urandom(), 16'($urandom()),
                                     13'($urandom()), 13'($urandom()),
                                     13'($urandom()), 13'($urandom()));
                    else if (roll == 1)
                        send_detect(16'(-int'($urandom_range(1, 32768))), 13'($urandom()),
                                    13'($urandom()), 13'($urandom()), 13'($urandom()));
                    else
                    begin
                        if ($urandom_range(0, 5) == 0)
                            keep_in[k] = !keep_in[k];
                        if (keep_in[k] && win_left <= win_right && win_top <= win_bottom)
                        begin
                            fx = $urandom_range(win_left, win_right);
                            fy = $urandom_range(win_top, win_bottom);
                            foot_box(fx, fy, bl, bt, br, bb);
                        end
                        else if ($urandom_range(0, 1) == 0)
                        begin
                            bl = 13'($urandom());
                            bt = 13'($urandom());
                            br = 13'($urandom());
                            bb = 13'($urandom());
                        end
                        else
                            foot_box(int'($urandom_range(0, 4195)) - 100,
                                     int'($urandom_range(0, 4195)) - 100, bl, bt, br, bb);
                        send_detect(pool_ids[k], bl, bt, br, bb);
                    end
                end
                if ($urandom_range(0, 40) == 0)
                    drain_reports();
            end
        end
    endtask

    // stimulus
    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_FRAME;
        time_ms    = '0;
        object_id  = '0;
        box_left   = '0;
        box_top    = '0;
        box_right  = '0;
        box_bottom = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_REGION_LEFT;
        cfg_data   = '0;
        win_left     = 12'd80;
        win_top      = 12'd80;
        win_right    = 12'd560;
        win_bottom   = 12'd560;
        stay_limit   = 32'd30000;
        lost_timeout = 32'd3000;
        now_ms       = '0;
        foreach (trk_used[i])
        begin
            trk_used[i]  = 1'b0;
            trk_seen[i]  = '0;
            trk_enter[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_limit();
        test_region_edges();
        test_table_full();
        test_random_traffic();

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
